@@ src/stx_etx_frame_receiver_top_macros.svh @@
// Assertion macros used by the frame receiver top level.
`ifndef STX_ETX_FRAME_RECEIVER_TOP_MACROS_SVH
`define STX_ETX_FRAME_RECEIVER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SEFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver assertion failed");

`endif

@@ src/sefr_pkg.sv @@
// Types, constants and helper functions for the STX/ETX frame receiver.
`default_nettype none

package sefr_pkg;

   localparam int BUF_DEPTH = 128;
   localparam int AW        = $clog2(BUF_DEPTH);
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
   localparam int MIN_FRAME = 4;

   localparam logic [7:0] STX_CODE       = 8'h02;
   localparam logic [7:0] ETX_CODE       = 8'h03;
   localparam logic [7:0] NUL_CODE       = 8'h00;
   localparam logic [7:0] DIGIT_NINE     = 8'h39;
   localparam logic [7:0] HEX_ALPHA_BIAS = 8'h37;
   localparam logic [7:0] HEX_DIGIT_BIAS = 8'h30;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_SUM = 2'd1,
      ST_SHORT   = 2'd2,
      ST_OVERRUN = 2'd3
   } status_type;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
      logic [6:0] read_index;
   } req_type;

   typedef struct packed {
      logic       is_read_reply;
      status_type frame_status;
      logic [7:0] frame_length;
      logic [7:0] read_data;
   } rsp_type;

   // Buffer write, clear and frame result from the frame controller.
   typedef struct packed {
      logic          wr_en;
      logic [AW-1:0] wr_addr;
      logic [7:0]    wr_data;
      logic          clr;
      logic          res_valid;
      status_type    status;
      logic [7:0]    length;
   } ctrl_type;

   // ASCII hex digit decode without validation.
   function automatic logic [7:0] hex_digit(input logic [7:0] c);
      return (c > DIGIT_NINE) ? (c - HEX_ALPHA_BIAS) : (c - HEX_DIGIT_BIAS);
   endfunction

endpackage

`default_nettype wire

@@ src/stx_etx_frame_receiver_top.sv @@
// STX/ETX frame receiver with XOR checksum check and frame buffer read access.
// Each transaction carries either a received byte or a read of one buffer position.
// One transaction is accepted per clock cycle while a result register is free or
// the result channel is ready; a frame status or read reply passes the pipeline
// register and then the output register before it reaches the result channel.
// The rate is set by the single pass of frame logic (running XOR, hex decode and
// compare) and by the buffer memory, which has one write and one registered read
// port. Bytes that produce no status (zero bytes, STX, frame body bytes) yield no
// result transaction. A result may wait while new transactions are still taken:
// a pipeline register and the output register hold up to two results.
`default_nettype none

`include "stx_etx_frame_receiver_top_macros.svh"

module stx_etx_frame_receiver_top
   import sefr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                 req_fire, byte_en, is_read;
   logic                 rd_in_range;
   logic [AW-1:0]        rd_addr;
   ctrl_type             ctrl;

   logic [7:0]           buf_mem_ff [BUF_DEPTH];
   logic [7:0]           rd_data_ff;
   logic [BUF_DEPTH-1:0] written_ff;

   logic                 s1_valid_ff, s1_valid_in;
   rsp_type              s1_res_ff, s1_res_in;
   logic                 s1_hit_ff, s1_hit_in;
   logic                 s1_move;

   logic                 out_valid_ff;
   rsp_type              out_ff, out_in;

   assign req_ready = !s1_valid_ff || !out_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_read   = (req_data.func == FUNC_READ);
   assign byte_en   = req_fire && (req_data.func == FUNC_BYTE);

   assign rd_in_range = (32'(req_data.read_index) < BUF_DEPTH);
   assign rd_addr     = AW'(req_data.read_index);

   sefr_frame_ctrl u_frame_ctrl (
      .clock   (clock),
      .reset   (reset),
      .byte_en (byte_en),
      .rx_byte (req_data.rx_byte),
      .ctrl    (ctrl)
   );

   // Frame buffer memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         buf_mem_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (req_fire) begin
         rd_data_ff <= buf_mem_ff[rd_addr];
      end
   end

   // Written flags; a rejected frame clears them all at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (ctrl.clr) begin
         written_ff <= '0;
      end else if (ctrl.wr_en) begin
         written_ff[ctrl.wr_addr] <= 1'b1;
      end
   end

   always_comb begin
      s1_res_in = '0;
      s1_res_in.frame_status = ST_OK;
      s1_hit_in = 1'b0;
      if (is_read) begin
         s1_valid_in             = 1'b1;
         s1_res_in.is_read_reply = 1'b1;
         s1_hit_in               = rd_in_range && written_ff[rd_addr];
      end else begin
         s1_valid_in            = ctrl.res_valid;
         s1_res_in.frame_status = ctrl.status;
         s1_res_in.frame_length = ctrl.length;
      end
   end

   assign s1_move = s1_valid_ff && (!out_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= s1_valid_in;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_res_ff <= s1_res_in;
         s1_hit_ff <= s1_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      out_in           = s1_res_ff;
      out_in.read_data = s1_hit_ff ? rd_data_ff : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // A pending result in the pipeline register is kept while the output stalls.
   `SEFR_ASSERT_NEXT(a_s1_holds, clock, reset,
      s1_valid_ff && out_valid_ff && !rsp_ready, s1_valid_ff)

   `SEFR_ASSERT_NEXT(a_clear_empties, clock, reset,
      ctrl.clr, written_ff == '0)

   `SEFR_ASSERT_SAME(a_read_reply_clean, clock, reset,
      out_valid_ff && out_ff.is_read_reply,
      out_ff.frame_status == ST_OK && out_ff.frame_length == 8'h00)

   `SEFR_ASSERT_SAME(a_ok_frame_length, clock, reset,
      out_valid_ff && !out_ff.is_read_reply && out_ff.frame_status == ST_OK,
      out_ff.frame_length != 8'd1 && out_ff.frame_length != 8'd2 &&
      out_ff.frame_length != 8'd3 && out_ff.read_data == 8'h00)

endmodule

`default_nettype wire

@@ src/sefr_frame_ctrl.sv @@
// Frame tracking, running XOR checksum and frame status decision.
`default_nettype none

module sefr_frame_ctrl
   import sefr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_en,
   input  logic [7:0] rx_byte,
   output ctrl_type   ctrl
);

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [7:0]       xor_ff, xor_in;
   logic [15:0]      last2_ff, last2_in;
   logic [CNT_W-1:0] next_fill;
   logic [7:0]       hi_dig, lo_dig, sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         xor_ff   <= '0;
         last2_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         xor_ff   <= xor_in;
         last2_ff <= last2_in;
      end
   end

   always_comb begin
      next_fill = fill_ff + CNT_W'(1);
      hi_dig    = hex_digit(last2_ff[15:8]);
      lo_dig    = hex_digit(last2_ff[7:0]);
      sum       = {hi_dig[3:0], 4'h0} + lo_dig;

      fill_in  = fill_ff;
      xor_in   = xor_ff;
      last2_in = last2_ff;

      ctrl           = '0;
      ctrl.wr_addr   = AW'(fill_ff);
      ctrl.wr_data   = rx_byte;
      ctrl.status    = ST_OK;

      if (byte_en && rx_byte != NUL_CODE) begin
         if (rx_byte == STX_CODE) begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = '0;
            fill_in      = CNT_W'(1);
            xor_in       = '0;
            last2_in     = '0;
         end else if (fill_ff != '0 && fill_ff < CNT_W'(BUF_DEPTH)) begin
            ctrl.wr_en = 1'b1;
            fill_in    = next_fill;
            if (rx_byte == ETX_CODE) begin
               ctrl.res_valid = 1'b1;
               fill_in        = '0;
               xor_in         = '0;
               last2_in       = '0;
               if (next_fill < CNT_W'(MIN_FRAME)) begin
                  ctrl.status = ST_SHORT;
                  ctrl.clr    = 1'b1;
               end else if (sum != xor_ff) begin
                  ctrl.status = ST_BAD_SUM;
                  ctrl.clr    = 1'b1;
               end else begin
                  ctrl.length = 8'(next_fill);
               end
            end else begin
               // The two newest bytes are held back; they may be the checksum digits.
               if (fill_ff >= CNT_W'(3)) begin
                  xor_in = xor_ff ^ last2_ff[15:8];
               end
               last2_in = {last2_ff[7:0], rx_byte};
               if (next_fill == CNT_W'(BUF_DEPTH)) begin
                  ctrl.res_valid = 1'b1;
                  ctrl.status    = ST_OVERRUN;
                  ctrl.clr       = 1'b1;
                  fill_in        = '0;
                  xor_in         = '0;
                  last2_in       = '0;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ test/stx_etx_frame_receiver_top_test.sv @@
// Self-checking testbench for the STX/ETX frame receiver: random byte stream and read access.
`timescale 1ns / 1ps

module stx_etx_frame_receiver_top_test;
   import sefr_pkg::*;

   localparam int LONG_HOLD    = 80;
   localparam int QUIET_ITEMS  = 120;
   localparam int TAIL_CYCLES  = 12;
   localparam int IDLE_LIMIT   = 1500;
   localparam int ITEM_TARGET  = 950;
   localparam int REPORT_LIMIT = 10;

   localparam int FRAME_GOOD    = 0;
   localparam int FRAME_BAD_SUM = 1;
   localparam int FRAME_LOWER   = 2;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_A    = 8'h41;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Local copy of the receiver state.
   logic [7:0]  frame_mem [BUF_DEPTH];
   bit          entry_valid [BUF_DEPTH];
   int unsigned fill_pos;
   logic [7:0]  xor_acc;
   logic [15:0] tail_bytes;

   req_type req_stream [$];
   rsp_type due_replies [$];

   int  total_items;
   int  quiet_from = 1 << 30;
   int  hold_at = -1;
   int  drain_at = -1;
   int  issued_reqs = 0;
   int  accepted_reqs = 0;
   int  error_count = 0;
   int  reads_seen = 0;
   int  status_seen [4];
   int  gap_left = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  stall_left = 0;
   logic req_fired = 1'b0;
   rsp_type want;

   stx_etx_frame_receiver_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] ascii_nibble(input logic [7:0] c);
      if (c > DIGIT_NINE) return c - HEX_ALPHA_BIAS;
      return c - HEX_DIGIT_BIAS;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return ASCII_ZERO + nib;
      return HEX_ALPHA_BIAS + nib;
   endfunction

   function automatic void close_frame(input bit wipe);
      int i;
      if (wipe) begin
         for (i = 0; i < BUF_DEPTH; i++) begin
            frame_mem[i]   = 8'h00;
            entry_valid[i] = 1'b0;
         end
      end
      fill_pos   = 0;
      xor_acc    = 8'h00;
      tail_bytes = 16'h0000;
   endfunction

   // Updates the local state for one accepted transaction and queues its reply, if any.
   function automatic void advance_frame_state(input req_type item);
      rsp_type     r;
      logic [7:0]  b;
      logic [7:0]  sum;
      int unsigned pos;
      r = '0;
      b = item.rx_byte;
      if (item.func == FUNC_READ) begin
         r.is_read_reply = 1'b1;
         if (item.read_index < BUF_DEPTH && entry_valid[item.read_index])
            r.read_data = frame_mem[item.read_index];
         due_replies.push_back(r);
         return;
      end
      if (b == NUL_CODE) return;
      if (b == STX_CODE) begin
         close_frame(1'b0);
         frame_mem[0]   = b;
         entry_valid[0] = 1'b1;
         fill_pos       = 1;
         return;
      end
      if (fill_pos == 0 || fill_pos >= BUF_DEPTH) return;
      pos = fill_pos;
      frame_mem[pos]   = b;
      entry_valid[pos] = 1'b1;
      fill_pos         = pos + 1;
      if (b == ETX_CODE) begin
         if (fill_pos < MIN_FRAME) begin
            r.frame_status = ST_SHORT;
            close_frame(1'b1);
         end else begin
            sum = (ascii_nibble(tail_bytes[15:8]) << 4) + ascii_nibble(tail_bytes[7:0]);
            if (sum != xor_acc) begin
               r.frame_status = ST_BAD_SUM;
               close_frame(1'b1);
            end else begin
               r.frame_status = ST_OK;
               r.frame_length = 8'(fill_pos);
               close_frame(1'b0);
            end
         end
         due_replies.push_back(r);
         return;
      end
      // The checksum bytes trail by two, so a byte joins the XOR only once two more follow.
      if (pos >= 3) xor_acc = xor_acc ^ tail_bytes[15:8];
      tail_bytes = {tail_bytes[7:0], b};
      if (fill_pos >= BUF_DEPTH) begin
         r.frame_status = ST_OVERRUN;
         close_frame(1'b1);
         due_replies.push_back(r);
      end
   endfunction

   task automatic push_byte(input logic [7:0] b);
      req_type item;
      item.func       = FUNC_BYTE;
      item.rx_byte    = b;
      item.read_index = 7'($urandom);
      req_stream.push_back(item);
   endtask

   task automatic push_read(input logic [6:0] idx);
      req_type item;
      item.func       = FUNC_READ;
      item.rx_byte    = 8'($urandom);
      item.read_index = idx;
      req_stream.push_back(item);
   endtask

   // Pushes STX, payload, two checksum characters and ETX; zero bytes are sprinkled in.
   task automatic push_frame(input int n_data, input int flavor);
      logic [7:0] b;
      logic [7:0] sum;
      logic [7:0] hi;
      logic [7:0] lo;
      int         k;
      sum = 8'h00;
      push_byte(STX_CODE);
      for (k = 0; k < n_data; k++) begin
         do b = 8'($urandom); while (b == NUL_CODE || b == STX_CODE || b == ETX_CODE);
         if ($urandom_range(0, 15) == 0) push_byte(NUL_CODE);
         push_byte(b);
         sum = sum ^ b;
      end
      hi = hex_char(sum[7:4]);
      lo = hex_char(sum[3:0]);
      if (flavor == FRAME_BAD_SUM) lo = lo ^ (8'h01 << $urandom_range(0, 7));
      if (flavor == FRAME_LOWER) begin
         hi = hi | 8'h20;
         lo = lo | 8'h20;
      end
      push_byte(hi);
      push_byte(lo);
      push_byte(ETX_CODE);
   endtask

   // Sender: one transaction is offered at a time and held until it is taken.
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_fired)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (req_stream.size() == 0 ||
                      (issued_reqs == drain_at && due_replies.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= req_stream.pop_front();
            issued_reqs++;
            if (issued_reqs < quiet_from && $urandom_range(0, 7) == 0)
               gap_left = $urandom_range(1, 6);
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off while reads keep arriving.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && hold_at >= 0 && accepted_reqs >= hold_at) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (accepted_reqs < quiet_from && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            advance_frame_state(req_data);
            accepted_reqs++;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_replies.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result read=%0b st=%0d len=%0d data=%02h",
                           $realtime, rsp_data.is_read_reply, rsp_data.frame_status,
                           rsp_data.frame_length, rsp_data.read_data);
            end else begin
               want = due_replies.pop_front();
               if (rsp_data.is_read_reply !== want.is_read_reply ||
                   rsp_data.frame_status !== want.frame_status ||
                   rsp_data.frame_length !== want.frame_length ||
                   rsp_data.read_data !== want.read_data) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch: expected read=%0b st=%0d len=%0d data=%02h",
                              $realtime, want.is_read_reply, want.frame_status,
                              want.frame_length, want.read_data);
                     $display("   got read=%0b st=%0d len=%0d data=%02h",
                              rsp_data.is_read_reply, rsp_data.frame_status,
                              rsp_data.frame_length, rsp_data.read_data);
                  end
               end
               if (want.is_read_reply) reads_seen++;
               else status_seen[want.frame_status]++;
            end
         end
      end
   end

   // Ends the run when neither channel completes a transaction for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int  k;
      int  n;
      int  pick;
      int  flav;
      bit  long_done;
      bit  overrun_done;
      long_done    = 1'b0;
      overrun_done = 1'b0;
      for (k = 0; k < 4; k++) status_seen[k] = 0;
      close_frame(1'b1);

      // Directed: reads of empty entries, ignored bytes, short, good, bad and restarted frames.
      push_read(7'd0);
      push_read(7'd127);
      push_byte(NUL_CODE);
      push_byte(ETX_CODE);
      push_byte(8'hFF);
      push_byte(STX_CODE);
      push_byte(ETX_CODE);
      push_byte(STX_CODE);
      push_byte(ASCII_A);
      push_byte(ETX_CODE);
      push_byte(STX_CODE);
      push_byte(ASCII_ZERO);
      push_byte(ASCII_ZERO);
      push_byte(ETX_CODE);
      push_read(7'd3);
      push_byte(STX_CODE);
      push_byte(ASCII_A);
      push_byte(ASCII_ZERO);
      push_byte(ASCII_ZERO);
      push_byte(ETX_CODE);
      push_read(7'd1);
      push_byte(STX_CODE);
      push_byte(ASCII_A);
      push_byte(STX_CODE);
      push_byte(ASCII_ZERO);
      push_byte(ASCII_ZERO);
      push_byte(ETX_CODE);
      push_read(7'd0);

      while (req_stream.size() < ITEM_TARGET) begin
         if (hold_at < 0 && req_stream.size() > 200) begin
            hold_at = req_stream.size();
            for (k = 0; k < 16; k++) push_read(7'($urandom_range(0, 15)));
         end else if (!long_done && req_stream.size() > 300) begin
            // A frame that ends exactly in the last buffer position.
            long_done = 1'b1;
            push_frame(BUF_DEPTH - 4, FRAME_GOOD);
            for (k = BUF_DEPTH - 8; k < BUF_DEPTH; k++) push_read(7'(k));
         end else if (drain_at < 0 && req_stream.size() > 500) begin
            drain_at = req_stream.size();
            push_frame($urandom_range(1, 6), FRAME_GOOD);
         end else if (!overrun_done && req_stream.size() > 620) begin
            overrun_done = 1'b1;
            push_frame(BUF_DEPTH - 3, FRAME_GOOD);
            push_read(7'd0);
            push_read(7'd127);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                               : $urandom_range(0, 10);
               flav = $urandom_range(0, 99);
               push_frame(n, (flav < 75) ? FRAME_GOOD :
                             (flav < 90) ? FRAME_BAD_SUM : FRAME_LOWER);
            end else if (pick < 80) begin
               n = $urandom_range(1, 4);
               for (k = 0; k < n; k++)
                  push_read($urandom_range(0, 1) ? 7'($urandom_range(0, 15)) : 7'($urandom));
            end else if (pick < 90) begin
               n = $urandom_range(1, 3);
               for (k = 0; k < n; k++) push_byte(8'($urandom));
            end else if (pick < 95) begin
               // Broken frame: arbitrary content, possibly never closed.
               push_byte(STX_CODE);
               n = $urandom_range(0, 5);
               for (k = 0; k < n; k++) push_byte(8'($urandom));
            end else begin
               push_byte(STX_CODE);
               if ($urandom_range(0, 1)) push_byte(8'($urandom_range(4, 255)));
               push_byte(ETX_CODE);
            end
         end
      end
      total_items = req_stream.size();
      quiet_from  = total_items - QUIET_ITEMS;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_reqs < total_items || due_replies.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d transactions: %0d ok, %0d bad sum, %0d short, %0d overrun frames.",
               accepted_reqs, status_seen[ST_OK], status_seen[ST_BAD_SUM],
               status_seen[ST_SHORT], status_seen[ST_OVERRUN]);
      $display("%0d reads, a %0d-cycle hold-off, a drain pause, full-depth frames; %0d errors.",
               reads_seen, LONG_HOLD, error_count);
      if (error_count == 0 && due_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ stx_etx_frame_receiver_top.f @@
+incdir+src
src/sefr_pkg.sv
src/sefr_frame_ctrl.sv
src/stx_etx_frame_receiver_top.sv
test/stx_etx_frame_receiver_top_test.sv
